[design/ewpp_pkg.sv]
`timescale 1ns / 1ps

package ewpp_pkg;

    // Field and datapath widths.
    localparam int PT_W        = 32;
    localparam int CAM_W       = 32;
    localparam int ROT_W       = 21;
    localparam int ROW_W       = 63;
    localparam int CFG_W       = 63;
    localparam int CFG_IDX_W   = 3;
    localparam int PROD_W      = 53;
    localparam int SUM_W       = 56;
    localparam int FRAC_DROP   = 19;
    localparam int PREP_W      = 34;
    localparam int MAG_W       = 33;
    localparam int WORD_W      = 64;
    localparam int SHIFT_W     = 6;
    localparam int ANGLE_W     = 44;
    localparam int ANGLE_FRAC  = 40;
    localparam int CORDIC_STEPS = 32;
    localparam int NORM_MSB    = 59;
    localparam int COLS_W      = 15;
    localparam int ROWS_W      = 14;
    localparam int U_W         = 23;
    localparam int V_W         = 22;
    localparam int UOFF_W      = 42;
    localparam int VOFF_W      = 41;
    localparam int UPROD_W     = 57;
    localparam int VPROD_W     = 55;
    localparam int U_SHIFT     = 33;
    localparam int V_SHIFT     = 32;

    localparam logic [WORD_W-1:0] PI_Q60 = 64'h3243_F6A8_885A_308D;

    // One half turn and one quarter turn in Q.40 half-turn units.
    localparam logic signed [ANGLE_W-1:0] ANG_ONE  = 44'sh100_0000_0000;
    localparam logic signed [ANGLE_W-1:0] ANG_HALF = 44'sh080_0000_0000;

    // Register reset values.
    localparam logic [ROW_W-1:0]  ROT_FIRST_RST  = 63'h2000_0000_0000_0000;
    localparam logic [ROW_W-1:0]  ROT_SECOND_RST = 63'h0000_0100_0000_0000;
    localparam logic [ROW_W-1:0]  ROT_THIRD_RST  = 63'h0000_0000_0008_0000;
    localparam logic [COLS_W-1:0] COLS_RST       = 15'd1920;
    localparam logic [ROWS_W-1:0] ROWS_RST       = 14'd960;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROT_ROW_FIRST,
        REG_ROT_ROW_SECOND,
        REG_ROT_ROW_THIRD,
        REG_SHIFT_X,
        REG_SHIFT_Y,
        REG_SHIFT_Z,
        REG_IMAGE_COLS,
        REG_IMAGE_ROWS
    } cfg_reg_t;

    typedef struct packed {
        logic signed [PT_W-1:0] point_x;
        logic signed [PT_W-1:0] point_y;
        logic signed [PT_W-1:0] point_z;
    } point_t;

    typedef struct packed {
        logic [U_W-1:0] pixel_u;
        logic [V_W-1:0] pixel_v;
    } pixel_t;

    // Operands after quadrant fold, with the shift that normalizes them.
    typedef struct packed {
        logic signed [PREP_W-1:0]  a;
        logic signed [PREP_W-1:0]  b;
        logic [SHIFT_W-1:0]        shift;
        logic signed [ANGLE_W-1:0] base;
    } prep_t;

    typedef struct packed {
        logic signed [WORD_W-1:0]  a;
        logic signed [WORD_W-1:0]  b;
        logic signed [ANGLE_W-1:0] acc;
    } cordic_t;

    typedef struct packed {
        logic [WORD_W-1:0] rem;
        logic [WORD_W-1:0] root;
    } sqrt_t;

    // Step angle atan(2^-idx)/pi in Q.40, built from the arctangent series
    // in Q.60 and a restoring division by pi. Evaluated at elaboration.
    function automatic logic [WORD_W-1:0] step_angle(input int idx);
        logic [WORD_W-1:0] sum;
        logic [WORD_W-1:0] term;
        logic [WORD_W-1:0] num;
        logic [WORD_W-1:0] rem;
        logic [WORD_W-1:0] den;
        logic [WORD_W-1:0] q;
        int e;
        int k;
        int bt;
        sum = '0;
        q   = '0;
        if (idx == 0) begin
            q = 64'd1 << (ANGLE_FRAC - 2);
        end else begin
            for (k = 0; k < 31; k++) begin
                e = 60 - idx * (2 * k + 1);
                if (e >= 0) begin
                    num  = 64'd1 << e;
                    den  = 64'(2 * k + 1);
                    term = '0;
                    rem  = '0;
                    for (bt = WORD_W - 1; bt >= 0; bt--) begin
                        rem = {rem[WORD_W-2:0], num[bt]};
                        if (rem >= den) begin
                            rem      = rem - den;
                            term[bt] = 1'b1;
                        end
                    end
                    if (k[0]) begin
                        sum = sum - term;
                    end else begin
                        sum = sum + term;
                    end
                end
            end
            rem = sum;
            for (k = 0; k < ANGLE_FRAC; k++) begin
                rem = rem << 1;
                q   = q << 1;
                if (rem >= PI_Q60) begin
                    rem  = rem - PI_Q60;
                    q[0] = 1'b1;
                end
            end
            if ((rem << 1) >= PI_Q60) begin
                q = q + 64'd1;
            end
        end
        return q;
    endfunction

    // Round-shifted camera sum clamped to the Q16.16 range.
    function automatic logic signed [CAM_W-1:0] cam_sat(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] s;
        logic signed [CAM_W-1:0] r;
        s = v >>> FRAC_DROP;
        if (&s[SUM_W-1:CAM_W-1] || ~|s[SUM_W-1:CAM_W-1]) begin
            r = s[CAM_W-1:0];
        end else if (s[SUM_W-1]) begin
            r = {1'b1, {(CAM_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(CAM_W-1){1'b1}}};
        end
        return r;
    endfunction

    // Fold the left half plane over and find the normalizing shift.
    function automatic prep_t prep_fn(input logic signed [PREP_W-1:0] a,
                                      input logic signed [PREP_W-1:0] b);
        prep_t p;
        logic [MAG_W-1:0] ma;
        logic [MAG_W-1:0] mb;
        logic [MAG_W-1:0] m;
        logic [SHIFT_W-1:0] pos;
        logic signed [PREP_W-1:0] nb;
        int j;
        p.a     = a;
        p.b     = b;
        p.base  = '0;
        if (a < 0) begin
            p.base = (b >= 0) ? ANG_ONE : -ANG_ONE;
            p.a    = -a;
            p.b    = -b;
        end
        nb  = -p.b;
        ma  = p.a[MAG_W-1:0];
        mb  = p.b[PREP_W-1] ? nb[MAG_W-1:0] : p.b[MAG_W-1:0];
        m   = (ma > mb) ? ma : mb;
        pos = '0;
        for (j = 0; j < MAG_W; j++) begin
            if (m[j]) begin
                pos = SHIFT_W'(j);
            end
        end
        p.shift = SHIFT_W'(NORM_MSB) - pos;
        return p;
    endfunction

    function automatic cordic_t cordic_load(input prep_t p);
        cordic_t c;
        c.a   = WORD_W'(p.a) <<< p.shift;
        c.b   = WORD_W'(p.b) <<< p.shift;
        c.acc = p.base;
        return c;
    endfunction

    // One vectoring rotation; a zero second component ends the sequence.
    function automatic cordic_t cordic_step(input cordic_t c, input int idx,
                                            input logic signed [ANGLE_W-1:0] ang);
        cordic_t r;
        logic signed [WORD_W-1:0] a;
        logic signed [WORD_W-1:0] b;
        logic signed [WORD_W-1:0] da;
        logic signed [WORD_W-1:0] db;
        logic signed [ANGLE_W-1:0] acc;
        a   = c.a;
        b   = c.b;
        acc = c.acc;
        r   = c;
        if (b != 0) begin
            da = b >>> idx;
            db = a >>> idx;
            if (b > 0) begin
                r.a   = a + da;
                r.b   = b - db;
                r.acc = acc + ang;
            end else begin
                r.a   = a - da;
                r.b   = b + db;
                r.acc = acc - ang;
            end
        end
        return r;
    endfunction

    // One digit of the restoring square root.
    function automatic sqrt_t sqrt_step(input sqrt_t s, input int idx);
        sqrt_t r;
        logic [WORD_W-1:0] bt;
        logic [WORD_W-1:0] t;
        bt = 64'd1 << (62 - 2 * idx);
        t  = s.root + bt;
        if (s.rem >= t) begin
            r.rem  = s.rem - t;
            r.root = (s.root >> 1) + bt;
        end else begin
            r.rem  = s.rem;
            r.root = s.root >> 1;
        end
        return r;
    endfunction

endpackage

[design/equirect_world_point_projection_top.sv]
`timescale 1ns / 1ps

// Projects world points to equirectangular pixels at one point per clock while
// the output is not stalled. A word passes 73 register stages: camera transform
// (2), squares and quadrant fold (2), 32 stages that run the square root of the
// horizontal distance beside the longitude rotations, rounding and latitude
// setup (3), 32 latitude rotations, and the pixel scaling (2). Each stage moves
// on as soon as the next one is free, so bubbles close up while the output word
// waits. Configuration registers feed the datapath directly; the user must write
// them only while no point is in flight, and the block does not enforce this.
module equirect_world_point_projection_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         point_valid,
    output logic                         point_ready,
    input  ewpp_pkg::point_t             point,
    output logic                         pixel_valid,
    input  logic                         pixel_ready,
    output ewpp_pkg::pixel_t             pixel,
    input  logic                         cfg_wr_en,
    input  logic [ewpp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ewpp_pkg::CFG_W-1:0]   cfg_wdata
);

    localparam int STEPS   = ewpp_pkg::CORDIC_STEPS;
    localparam int ROT_W   = ewpp_pkg::ROT_W;
    localparam int ROW_W   = ewpp_pkg::ROW_W;
    localparam int PROD_W  = ewpp_pkg::PROD_W;
    localparam int SUM_W   = ewpp_pkg::SUM_W;
    localparam int CAM_W   = ewpp_pkg::CAM_W;
    localparam int PREP_W  = ewpp_pkg::PREP_W;
    localparam int MAG_W   = ewpp_pkg::MAG_W;
    localparam int WORD_W  = ewpp_pkg::WORD_W;
    localparam int ANGLE_W = ewpp_pkg::ANGLE_W;

    localparam int ST_PROD = 0;
    localparam int ST_CAM  = 1;
    localparam int ST_SQ   = 2;
    localparam int ST_A0   = 3;
    localparam int ST_RND  = ST_A0 + STEPS + 1;
    localparam int ST_NPRE = ST_RND + 1;
    localparam int ST_B0   = ST_NPRE + 1;
    localparam int ST_MUL  = ST_B0 + STEPS + 1;
    localparam int ST_OUT  = ST_MUL + 1;
    localparam int NSTG    = ST_OUT + 1;

    // Configuration registers.
    logic [ROW_W-1:0]                  rot_reg [3];
    logic signed [ewpp_pkg::PT_W-1:0]  shift_reg [3];
    logic [ewpp_pkg::COLS_W-1:0]       cols_reg;
    logic [ewpp_pkg::ROWS_W-1:0]       rows_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_reg[0]   <= ewpp_pkg::ROT_FIRST_RST;
            rot_reg[1]   <= ewpp_pkg::ROT_SECOND_RST;
            rot_reg[2]   <= ewpp_pkg::ROT_THIRD_RST;
            shift_reg[0] <= '0;
            shift_reg[1] <= '0;
            shift_reg[2] <= '0;
            cols_reg     <= ewpp_pkg::COLS_RST;
            rows_reg     <= ewpp_pkg::ROWS_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (ewpp_pkg::cfg_reg_t'(cfg_index))
                ewpp_pkg::REG_ROT_ROW_FIRST:  rot_reg[0]   <= cfg_wdata;
                ewpp_pkg::REG_ROT_ROW_SECOND: rot_reg[1]   <= cfg_wdata;
                ewpp_pkg::REG_ROT_ROW_THIRD:  rot_reg[2]   <= cfg_wdata;
                ewpp_pkg::REG_SHIFT_X:        shift_reg[0] <= cfg_wdata[CAM_W-1:0];
                ewpp_pkg::REG_SHIFT_Y:        shift_reg[1] <= cfg_wdata[CAM_W-1:0];
                ewpp_pkg::REG_SHIFT_Z:        shift_reg[2] <= cfg_wdata[CAM_W-1:0];
                ewpp_pkg::REG_IMAGE_COLS:     cols_reg <= cfg_wdata[ewpp_pkg::COLS_W-1:0];
                ewpp_pkg::REG_IMAGE_ROWS:     rows_reg <= cfg_wdata[ewpp_pkg::ROWS_W-1:0];
            endcase
        end
    end

    // Stage valid bits and the advance chain: a stage loads when it is
    // empty or its content moves on.
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] adv;

    always_comb
    begin
        adv[NSTG-1] = !vld_reg[NSTG-1] || pixel_ready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
        vld_next = {vld_reg[NSTG-2:0], point_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NSTG; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_next[k];
                end
            end
        end
    end

    assign point_ready = adv[ST_PROD];
    assign pixel_valid = vld_reg[ST_OUT];

    // Rotation products, one per matrix entry.
    localparam int PT_W_L = ewpp_pkg::PT_W;
    logic signed [PT_W_L-1:0] pt [3];
    logic signed [PROD_W-1:0] prod_next [3][3];
    logic signed [PROD_W-1:0] prod_reg  [3][3];

    assign pt[0] = point.point_x;
    assign pt[1] = point.point_y;
    assign pt[2] = point.point_z;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                prod_next[r][c] = PROD_W'($signed(rot_reg[r][ROW_W-1-ROT_W*c -: ROT_W]))
                                  * PROD_W'(pt[c]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[ST_PROD])
        begin
            prod_reg <= prod_next;
        end
    end

    // Row sums plus translation, rounded to Q16.16 and saturated.
    logic signed [SUM_W-1:0] row_sum [3];
    logic signed [CAM_W-1:0] cam_next [3];
    logic signed [CAM_W-1:0] cam_reg  [3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            row_sum[r] = SUM_W'(prod_reg[r][0]) + SUM_W'(prod_reg[r][1])
                       + SUM_W'(prod_reg[r][2])
                       + (SUM_W'(shift_reg[r]) <<< ewpp_pkg::FRAC_DROP)
                       + (SUM_W'(1) <<< (ewpp_pkg::FRAC_DROP - 1));
            cam_next[r] = ewpp_pkg::cam_sat(row_sum[r]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[ST_CAM])
        begin
            cam_reg <= cam_next;
        end
    end

    // Squares for the horizontal distance and longitude operand fold.
    logic signed [WORD_W-1:0] sqx_s;
    logic signed [WORD_W-1:0] sqz_s;
    logic [WORD_W-1:0]        sqx_reg;
    logic [WORD_W-1:0]        sqz_reg;
    ewpp_pkg::prep_t          lon_prep_next;
    ewpp_pkg::prep_t          lon_prep_reg;
    logic signed [CAM_W-1:0]  cy_sq_reg;

    assign sqx_s         = WORD_W'(cam_reg[0]) * WORD_W'(cam_reg[0]);
    assign sqz_s         = WORD_W'(cam_reg[2]) * WORD_W'(cam_reg[2]);
    assign lon_prep_next = ewpp_pkg::prep_fn(PREP_W'(cam_reg[2]), PREP_W'(cam_reg[0]));

    always_ff @(posedge clk)
    begin
        if (adv[ST_SQ])
        begin
            sqx_reg      <= $unsigned(sqx_s);
            sqz_reg      <= $unsigned(sqz_s);
            lon_prep_reg <= lon_prep_next;
            cy_sq_reg    <= cam_reg[1];
        end
    end

    // Square root beside the longitude rotations.
    ewpp_pkg::sqrt_t          a_sq_reg  [STEPS+1];
    ewpp_pkg::sqrt_t          a_sq_next [STEPS+1];
    ewpp_pkg::cordic_t        a_cd_reg  [STEPS+1];
    ewpp_pkg::cordic_t        a_cd_next [STEPS+1];
    logic signed [CAM_W-1:0]  a_cy_reg  [STEPS+1];

    assign a_sq_next[0].rem  = sqx_reg + sqz_reg;
    assign a_sq_next[0].root = '0;
    assign a_cd_next[0]      = ewpp_pkg::cordic_load(lon_prep_reg);

    always_ff @(posedge clk)
    begin
        if (adv[ST_A0])
        begin
            a_sq_reg[0] <= a_sq_next[0];
            a_cd_reg[0] <= a_cd_next[0];
            a_cy_reg[0] <= cy_sq_reg;
        end
    end

    for (genvar j = 0; j < STEPS; j++)
    begin : g_lon
        localparam logic signed [ANGLE_W-1:0] ANG = ANGLE_W'(ewpp_pkg::step_angle(j));

        assign a_sq_next[j+1] = ewpp_pkg::sqrt_step(a_sq_reg[j], j);
        assign a_cd_next[j+1] = ewpp_pkg::cordic_step(a_cd_reg[j], j, ANG);

        always_ff @(posedge clk)
        begin
            if (adv[ST_A0+1+j])
            begin
                a_sq_reg[j+1] <= a_sq_next[j+1];
                a_cd_reg[j+1] <= a_cd_next[j+1];
                a_cy_reg[j+1] <= a_cy_reg[j];
            end
        end
    end

    // Round the root to nearest and clamp the longitude.
    logic [MAG_W-1:0]          h_next;
    logic [MAG_W-1:0]          h_reg;
    logic signed [ANGLE_W-1:0] lon_acc;
    logic signed [ANGLE_W-1:0] lon_next;
    logic signed [ANGLE_W-1:0] lon_rnd_reg;
    logic signed [CAM_W-1:0]   cy_rnd_reg;

    assign h_next = MAG_W'(a_sq_reg[STEPS].root)
                  + MAG_W'(a_sq_reg[STEPS].rem > a_sq_reg[STEPS].root);
    assign lon_acc = a_cd_reg[STEPS].acc;

    always_comb
    begin
        if (lon_acc > ewpp_pkg::ANG_ONE)
        begin
            lon_next = ewpp_pkg::ANG_ONE;
        end
        else if (lon_acc < -ewpp_pkg::ANG_ONE)
        begin
            lon_next = -ewpp_pkg::ANG_ONE;
        end
        else
        begin
            lon_next = lon_acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[ST_RND])
        begin
            h_reg       <= h_next;
            lon_rnd_reg <= lon_next;
            cy_rnd_reg  <= a_cy_reg[STEPS];
        end
    end

    // Latitude operand normalization.
    ewpp_pkg::prep_t           lat_prep_next;
    ewpp_pkg::prep_t           lat_prep_reg;
    logic signed [ANGLE_W-1:0] lon_pre_reg;

    assign lat_prep_next = ewpp_pkg::prep_fn(PREP_W'(h_reg), PREP_W'(cy_rnd_reg));

    always_ff @(posedge clk)
    begin
        if (adv[ST_NPRE])
        begin
            lat_prep_reg <= lat_prep_next;
            lon_pre_reg  <= lon_rnd_reg;
        end
    end

    // Latitude rotations.
    ewpp_pkg::cordic_t         b_cd_reg  [STEPS+1];
    ewpp_pkg::cordic_t         b_cd_next [STEPS+1];
    logic signed [ANGLE_W-1:0] b_lon_reg [STEPS+1];

    assign b_cd_next[0] = ewpp_pkg::cordic_load(lat_prep_reg);

    always_ff @(posedge clk)
    begin
        if (adv[ST_B0])
        begin
            b_cd_reg[0]  <= b_cd_next[0];
            b_lon_reg[0] <= lon_pre_reg;
        end
    end

    for (genvar j = 0; j < STEPS; j++)
    begin : g_lat
        localparam logic signed [ANGLE_W-1:0] ANG = ANGLE_W'(ewpp_pkg::step_angle(j));

        assign b_cd_next[j+1] = ewpp_pkg::cordic_step(b_cd_reg[j], j, ANG);

        always_ff @(posedge clk)
        begin
            if (adv[ST_B0+1+j])
            begin
                b_cd_reg[j+1]  <= b_cd_next[j+1];
                b_lon_reg[j+1] <= b_lon_reg[j];
            end
        end
    end

    // Clamp the latitude and scale both angles to the image size.
    logic signed [ANGLE_W-1:0]       lat_acc;
    logic signed [ANGLE_W-1:0]       nlat;
    logic signed [ANGLE_W-1:0]       u_off;
    logic signed [ANGLE_W-1:0]       v_off;
    logic [ewpp_pkg::UPROD_W-1:0]    u_prod_next;
    logic [ewpp_pkg::VPROD_W-1:0]    v_prod_next;
    logic [ewpp_pkg::UPROD_W-1:0]    u_prod_reg;
    logic [ewpp_pkg::VPROD_W-1:0]    v_prod_reg;

    assign lat_acc = b_cd_reg[STEPS].acc;

    always_comb
    begin
        if (lat_acc > ewpp_pkg::ANG_HALF)
        begin
            nlat = ewpp_pkg::ANG_HALF;
        end
        else if (lat_acc < -ewpp_pkg::ANG_HALF)
        begin
            nlat = -ewpp_pkg::ANG_HALF;
        end
        else
        begin
            nlat = lat_acc;
        end
        u_off       = ewpp_pkg::ANG_ONE + b_lon_reg[STEPS];
        v_off       = ewpp_pkg::ANG_HALF + nlat;
        u_prod_next = ewpp_pkg::UPROD_W'(cols_reg)
                    * ewpp_pkg::UPROD_W'(u_off[ewpp_pkg::UOFF_W-1:0]);
        v_prod_next = ewpp_pkg::VPROD_W'(rows_reg)
                    * ewpp_pkg::VPROD_W'(v_off[ewpp_pkg::VOFF_W-1:0]);
    end

    always_ff @(posedge clk)
    begin
        if (adv[ST_MUL])
        begin
            u_prod_reg <= u_prod_next;
            v_prod_reg <= v_prod_next;
        end
    end

    // Round half up to 8 fraction bits and hold the output word.
    logic [ewpp_pkg::UPROD_W-1:0] u_rnd;
    logic [ewpp_pkg::VPROD_W-1:0] v_rnd;
    ewpp_pkg::pixel_t             pixel_next;
    ewpp_pkg::pixel_t             pixel_reg;

    assign u_rnd = (u_prod_reg + (ewpp_pkg::UPROD_W'(1) << (ewpp_pkg::U_SHIFT - 1)))
                   >> ewpp_pkg::U_SHIFT;
    assign v_rnd = (v_prod_reg + (ewpp_pkg::VPROD_W'(1) << (ewpp_pkg::V_SHIFT - 1)))
                   >> ewpp_pkg::V_SHIFT;
    assign pixel_next.pixel_u = u_rnd[ewpp_pkg::U_W-1:0];
    assign pixel_next.pixel_v = v_rnd[ewpp_pkg::V_W-1:0];

    always_ff @(posedge clk)
    begin
        if (adv[ST_OUT])
        begin
            pixel_reg <= pixel_next;
        end
    end

    assign pixel = pixel_reg;

endmodule
